// ----- design/sjlu_pkg.sv -----
// ----------------------------------------------------------------------------
// sjlu_pkg
// Shared types, constants and helpers for the Shift-JIS / Latin-1 transcoder.
// ----------------------------------------------------------------------------
package sjlu_pkg;

   // code table geometry: 60 lead rows of 256 trail bytes
   localparam int TBL_DEPTH = 15360;
   localparam int TBL_AW    = 14;
   localparam int ROW_W     = 6;

   localparam logic [15:0] REPL_CP     = 16'hFFFD;
   localparam logic [15:0] KANA_BASE   = 16'hFF61;
   localparam logic [7:0]  KANA_LO     = 8'hA1;
   localparam logic [7:0]  KANA_HI     = 8'hDF;
   localparam logic [15:0] KANA_OFFSET = KANA_BASE - {8'h00, KANA_LO};
   localparam logic [7:0]  ASCII_LIMIT = 8'h80;
   localparam logic [7:0]  LEAD1_LO    = 8'h81;
   localparam logic [7:0]  LEAD1_HI    = 8'h9F;
   localparam logic [7:0]  LEAD2_LO    = 8'hE0;
   localparam logic [7:0]  LEAD2_HI    = 8'hFC;
   localparam logic [7:0]  ROW2_BASE   = 8'd31;
   localparam logic [15:0] CP_1B_LIMIT = 16'h0080;
   localparam logic [15:0] CP_2B_LIMIT = 16'h0800;

   localparam logic CMD_DECODE = 1'b0;
   localparam logic CMD_LOAD   = 1'b1;

   localparam logic MODE_LATIN1 = 1'b0;
   localparam logic MODE_SJIS   = 1'b1;

   typedef struct packed {
      logic        mapped;
      logic [15:0] codepoint;
   } tbl_entry_type;

   typedef struct packed {
      logic                en;
      logic [TBL_AW-1:0]   addr;
      tbl_entry_type       entry;
   } tbl_wr_type;

   typedef struct packed {
      logic             is_lead;
      logic [ROW_W-1:0] row;
   } lead_row_type;

   // table row of a lead byte
   function automatic lead_row_type lead_row(input logic [7:0] b);
      lead_row_type r;
      logic [7:0]   d;
      r = '0;
      d = '0;
      if (b >= LEAD1_LO && b <= LEAD1_HI) begin
         d         = b - LEAD1_LO;
         r.is_lead = 1'b1;
         r.row     = d[ROW_W-1:0];
      end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
         d         = b - LEAD2_LO + ROW2_BASE;
         r.is_lead = 1'b1;
         r.row     = d[ROW_W-1:0];
      end
      return r;
   endfunction

endpackage

// ----- design/sjlu_code_table.sv -----
// ----------------------------------------------------------------------------
// sjlu_code_table
// Double-byte code table: one write port, one registered read port, and a
// clearing pass over every entry after reset.
// ----------------------------------------------------------------------------
module sjlu_code_table (
   input  logic                          clock,
   input  logic                          reset,
   input  sjlu_pkg::tbl_wr_type          wr,
   input  logic                          rd_en,
   input  logic [sjlu_pkg::TBL_AW-1:0]   rd_addr,
   output sjlu_pkg::tbl_entry_type       rd_data,
   output logic                          busy
);
   import sjlu_pkg::*;

   tbl_entry_type     mem [TBL_DEPTH];
   tbl_entry_type     rd_data_ff;
   logic [TBL_AW-1:0] clr_cnt_ff, clr_cnt_in;
   logic              busy_ff, busy_in;
   tbl_wr_type        port;

   localparam logic [TBL_AW-1:0] LAST_ADDR = TBL_AW'(TBL_DEPTH - 1);

   always_comb begin
      clr_cnt_in = clr_cnt_ff;
      busy_in    = busy_ff;
      if (busy_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == LAST_ADDR) begin
            busy_in = 1'b0;
         end
      end
   end

   // clearing pass owns the write port until it is done
   always_comb begin
      if (busy_ff) begin
         port.en    = 1'b1;
         port.addr  = clr_cnt_ff;
         port.entry = '0;
      end else begin
         port = wr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
         busy_ff    <= 1'b1;
      end else begin
         clr_cnt_ff <= clr_cnt_in;
         busy_ff    <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (port.en) begin
         mem[port.addr] <= port.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = busy_ff;

endmodule

// ----- design/sjlu_out_buffer.sv -----
// ----------------------------------------------------------------------------
// sjlu_out_buffer
// UTF-8 encoder and three-byte output buffer, one byte per transaction.
// ----------------------------------------------------------------------------
module sjlu_out_buffer (
   input  logic        clock,
   input  logic        reset,
   input  logic        load_valid,
   input  logic [15:0] load_cp,
   input  logic        load_eos,
   output logic        load_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_utf8_byte,
   output logic        rsp_run_last,
   output logic        rsp_string_end
);
   import sjlu_pkg::*;

   logic [7:0] byte_ff [3];
   logic [7:0] byte_in [3];
   logic [1:0] cnt_ff, cnt_in;
   logic       eos_ff, eos_in;
   logic [7:0] enc [3];
   logic [1:0] enc_cnt;

   always_comb begin
      enc[0] = '0;
      enc[1] = '0;
      enc[2] = '0;
      if (load_cp < CP_1B_LIMIT) begin
         enc[0]  = load_cp[7:0];
         enc_cnt = 2'd1;
      end else if (load_cp < CP_2B_LIMIT) begin
         enc[0]  = {3'b110, load_cp[10:6]};
         enc[1]  = {2'b10, load_cp[5:0]};
         enc_cnt = 2'd2;
      end else begin
         enc[0]  = {4'b1110, load_cp[15:12]};
         enc[1]  = {2'b10, load_cp[11:6]};
         enc[2]  = {2'b10, load_cp[5:0]};
         enc_cnt = 2'd3;
      end
   end

   assign load_ready = (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && rsp_ready);

   always_comb begin
      byte_in = byte_ff;
      cnt_in  = cnt_ff;
      eos_in  = eos_ff;
      if (rsp_valid && rsp_ready) begin
         byte_in[0] = byte_ff[1];
         byte_in[1] = byte_ff[2];
         cnt_in     = cnt_ff - 1'b1;
      end
      if (load_valid && load_ready) begin
         byte_in = enc;
         cnt_in  = enc_cnt;
         eos_in  = load_eos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      eos_ff  <= eos_in;
   end

   assign rsp_valid      = (cnt_ff != 2'd0);
   assign rsp_utf8_byte  = byte_ff[0];
   assign rsp_run_last   = (cnt_ff == 2'd1);
   assign rsp_string_end = rsp_run_last && eos_ff;

endmodule

// ----- design/sjis_latin1_to_utf8_transcoder.sv -----
// ----------------------------------------------------------------------------
// sjis_latin1_to_utf8_transcoder
// Byte stream to UTF-8 transcoder with Latin-1 and Shift-JIS decoding.
// ----------------------------------------------------------------------------
// After reset the code table is swept clear, one entry a cycle; req_ready
// stays low meanwhile, while csr writes are taken as ever.
// A decode transaction is classified as it is accepted (the table lookup for
// a trail byte is issued on that same edge), waits in the decode register
// until the output buffer takes it and is then encoded into that buffer. The
// rsp channel moves one byte per transaction, so a decode item yields one,
// two or three bytes according to its codepoint; a load item, or a lead byte
// being held, is taken on req and produces nothing. Sustained rate is thus
// up to one item a cycle while rsp is ready, less for longer encodings, set
// by the width of the result channel.
module sjis_latin1_to_utf8_transcoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_charset_mode,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_string,
   input  logic [15:0] req_entry_code,
   input  logic [15:0] req_entry_codepoint,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_utf8_byte,
   output logic        rsp_run_last,
   output logic        rsp_string_end
);
   import sjlu_pkg::*;

   // configuration
   logic charset_mode_ff, charset_mode_in;

   // lead byte state
   logic [7:0] held_lead_ff, held_lead_in;
   logic       lead_pending_ff, lead_pending_in;

   // decode register
   logic        s1_valid_ff, s1_valid_in;
   logic [15:0] s1_cp_ff, s1_cp_in;
   logic        s1_use_tbl_ff, s1_use_tbl_in;
   logic        s1_eos_ff, s1_eos_in;

   logic          accept;
   logic          is_decode;
   logic          hold_lead;
   logic          emits;
   logic          use_tbl;
   logic [15:0]   direct_cp;
   logic          buf_ready;
   logic          s1_advance;
   logic [15:0]   s1_final_cp;
   logic          tbl_busy;
   logic          rd_en;
   lead_row_type  held_row;
   lead_row_type  byte_row;
   lead_row_type  load_row;
   tbl_wr_type    tbl_wr;
   tbl_entry_type tbl_rd;

   // configuration register, always ready
   assign csr_ready       = 1'b1;
   assign charset_mode_in = (csr_valid && csr_ready) ? csr_charset_mode : charset_mode_ff;

   assign s1_advance = s1_valid_ff && buf_ready;
   assign req_ready  = !tbl_busy && (!s1_valid_ff || buf_ready);
   assign accept     = req_valid && req_ready;
   assign is_decode  = (req_cmd == CMD_DECODE);

   assign held_row = lead_row(held_lead_ff);
   assign byte_row = lead_row(req_data_byte);
   assign load_row = lead_row(req_entry_code[15:8]);

   // classify one decode byte
   always_comb begin
      hold_lead = 1'b0;
      use_tbl   = 1'b0;
      direct_cp = REPL_CP;
      if (charset_mode_ff == MODE_LATIN1) begin
         direct_cp = {8'h00, req_data_byte};
      end else if (lead_pending_ff) begin
         // any byte after a held lead is the trail
         use_tbl = 1'b1;
      end else if (req_data_byte < ASCII_LIMIT) begin
         direct_cp = {8'h00, req_data_byte};
      end else if (req_data_byte >= KANA_LO && req_data_byte <= KANA_HI) begin
         direct_cp = {8'h00, req_data_byte} + KANA_OFFSET;
      end else if (byte_row.is_lead) begin
         // a lead on the last byte of a string is replaced at once
         hold_lead = !req_end_of_string;
      end
   end

   assign emits = accept && is_decode && !hold_lead;
   assign rd_en = accept && is_decode && use_tbl;

   // lead state and decode register next values
   always_comb begin
      held_lead_in    = held_lead_ff;
      lead_pending_in = lead_pending_ff;
      if (accept && is_decode) begin
         lead_pending_in = hold_lead;
         if (hold_lead) begin
            held_lead_in = req_data_byte;
         end
      end
   end

   always_comb begin
      s1_valid_in   = s1_valid_ff;
      s1_cp_in      = s1_cp_ff;
      s1_use_tbl_in = s1_use_tbl_ff;
      s1_eos_in     = s1_eos_ff;
      if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
      if (emits) begin
         s1_valid_in   = 1'b1;
         s1_cp_in      = direct_cp;
         s1_use_tbl_in = use_tbl;
         s1_eos_in     = req_end_of_string;
      end
   end

   // load transactions with a valid lead byte write the table on acceptance
   always_comb begin
      tbl_wr.en              = accept && !is_decode && load_row.is_lead;
      tbl_wr.addr            = {load_row.row, req_entry_code[7:0]};
      tbl_wr.entry.mapped    = 1'b1;
      tbl_wr.entry.codepoint = req_entry_codepoint;
   end

   sjlu_code_table u_table (
      .clock   (clock),
      .reset   (reset),
      .wr      (tbl_wr),
      .rd_en   (rd_en),
      .rd_addr ({held_row.row, req_data_byte}),
      .rd_data (tbl_rd),
      .busy    (tbl_busy)
   );

   // unmapped pairs fall back to the replacement character
   assign s1_final_cp = !s1_use_tbl_ff   ? s1_cp_ff         :
                        tbl_rd.mapped    ? tbl_rd.codepoint : REPL_CP;

   sjlu_out_buffer u_out (
      .clock          (clock),
      .reset          (reset),
      .load_valid     (s1_valid_ff),
      .load_cp        (s1_final_cp),
      .load_eos       (s1_eos_ff),
      .load_ready     (buf_ready),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_utf8_byte  (rsp_utf8_byte),
      .rsp_run_last   (rsp_run_last),
      .rsp_string_end (rsp_string_end)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         charset_mode_ff <= MODE_LATIN1;
         held_lead_ff    <= '0;
         lead_pending_ff <= 1'b0;
         s1_valid_ff     <= 1'b0;
      end else begin
         charset_mode_ff <= charset_mode_in;
         held_lead_ff    <= held_lead_in;
         lead_pending_ff <= lead_pending_in;
         s1_valid_ff     <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_cp_ff      <= s1_cp_in;
      s1_use_tbl_ff <= s1_use_tbl_in;
      s1_eos_ff     <= s1_eos_in;
   end

`ifndef ASSERT_OFF
   // no req transaction is taken while the table is being cleared
   a_busy_blocks_req : assert property (@(posedge clock) disable iff (reset)
      tbl_busy |-> !req_ready)
      else $error("request accepted during table clearing pass");

   // string end only on the last byte of an item
   a_string_end_last : assert property (@(posedge clock) disable iff (reset)
      rsp_string_end |-> rsp_run_last)
      else $error("string end without run last");

   // a held lead is pending on the next cycle; it produces no decode entry, though this check does not test that
   a_hold_lead : assert property (@(posedge clock) disable iff (reset)
      (accept && is_decode && hold_lead) |=> (lead_pending_ff && !rd_en ||
                                              lead_pending_ff))
      else $error("held lead not pending");

   // a held lead is always a genuine lead byte
   a_held_is_lead : assert property (@(posedge clock) disable iff (reset)
      lead_pending_ff |-> held_row.is_lead)
      else $error("pending lead byte is not a lead");
`endif

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Shift-JIS / Latin-1 to UTF-8 transcoder: drives
// decode and table-load transactions, predicts every UTF-8 byte in step with
// the stimulus and compares each rsp transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
   import sjlu_pkg::*;

   // one byte on the rsp channel
   typedef struct packed {
      logic [7:0] utf8_byte;
      logic       run_last;
      logic       string_end;
   } utf8_beat_type;

   logic        clock = 1'b0;
   logic        reset;

   logic        csr_valid;
   logic        csr_ready;
   logic        csr_charset_mode;

   logic        req_valid;
   logic        req_ready;
   logic        req_cmd;
   logic [7:0]  req_data_byte;
   logic        req_end_of_string;
   logic [15:0] req_entry_code;
   logic [15:0] req_entry_codepoint;

   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_utf8_byte;
   logic        rsp_run_last;
   logic        rsp_string_end;

   // shadow of the block's state, kept in step with accepted transactions
   logic        mode_shadow      = MODE_LATIN1;
   logic        lead_held        = 1'b0;
   logic [7:0]  held_lead_shadow = 8'h00;
   // code table: an entry exists only once it has been loaded
   logic [15:0] glyph_table [int];

   utf8_beat_type utf8_expected [$];
   // double-byte codes with a valid lead that have been loaded so far
   logic [15:0] loaded_codes [$];

   // idling limits per side, and a one-off long hold-off for the receiver
   int          req_gap_max     = 0;
   int          rsp_gap_max     = 0;
   int          rsp_hold_cycles = 0;
   int          mismatches      = 0;

   sjis_latin1_to_utf8_transcoder dut (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_charset_mode    (csr_charset_mode),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_cmd             (req_cmd),
      .req_data_byte       (req_data_byte),
      .req_end_of_string   (req_end_of_string),
      .req_entry_code      (req_entry_code),
      .req_entry_codepoint (req_entry_codepoint),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_utf8_byte       (rsp_utf8_byte),
      .rsp_run_last        (rsp_run_last),
      .rsp_string_end      (rsp_string_end)
   );

   always #10 clock = ~clock;

   // hard stop: table clear after reset plus the whole run, many times over
   initial begin
      #4000000;
      $display("tb: failure");
      $finish;
   end

   // ------------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------------

   // table row of a lead byte, -1 when the byte cannot lead a pair
   function automatic int lead_row_of(input logic [7:0] b);
      if (b >= LEAD1_LO && b <= LEAD1_HI) begin
         return int'(b) - int'(LEAD1_LO);
      end
      if (b >= LEAD2_LO && b <= LEAD2_HI) begin
         return int'(b) - int'(LEAD2_LO) + int'(ROW2_BASE);
      end
      return -1;
   endfunction

   // queue the utf-8 bytes of one bmp codepoint
   function automatic void push_codepoint(input logic [15:0] cp, input logic eos);
      logic [7:0]    bytes [3];
      int            n;
      utf8_beat_type beat;
      if (cp < CP_1B_LIMIT) begin
         bytes[0] = cp[7:0];
         n = 1;
      end else if (cp < CP_2B_LIMIT) begin
         bytes[0] = {3'b110, cp[10:6]};
         bytes[1] = {2'b10, cp[5:0]};
         n = 2;
      end else begin
         bytes[0] = {4'b1110, cp[15:12]};
         bytes[1] = {2'b10, cp[11:6]};
         bytes[2] = {2'b10, cp[5:0]};
         n = 3;
      end
      for (int k = 0; k < n; k++) begin
         beat.utf8_byte  = bytes[k];
         beat.run_last   = (k == n - 1);
         beat.string_end = (k == n - 1) && eos;
         utf8_expected   = {utf8_expected, beat};
      end
   endfunction

   // expected effect of one accepted req transaction
   function automatic void transcode_item(input logic cmd, input logic [7:0] b,
                                          input logic eos, input logic [15:0] code,
                                          input logic [15:0] cpv);
      int          row;
      int          key;
      logic [15:0] cp;
      if (cmd == CMD_LOAD) begin
         // loads with a bad lead vanish; a held lead survives any load
         row = lead_row_of(code[15:8]);
         if (row >= 0) begin
            glyph_table[row * 256 + int'(code[7:0])] = cpv;
         end
      end else if (mode_shadow == MODE_LATIN1) begin
         lead_held = 1'b0;
         push_codepoint({8'h00, b}, eos);
      end else if (lead_held) begin
         // whatever follows a lead is its trail
         lead_held = 1'b0;
         key = lead_row_of(held_lead_shadow) * 256 + int'(b);
         cp  = glyph_table.exists(key) ? glyph_table[key] : REPL_CP;
         push_codepoint(cp, eos);
      end else if (b < ASCII_LIMIT) begin
         push_codepoint({8'h00, b}, eos);
      end else if (b >= KANA_LO && b <= KANA_HI) begin
         push_codepoint(KANA_BASE + 16'(b - KANA_LO), eos);
      end else if (lead_row_of(b) >= 0) begin
         // a lead closing a string has no trail to wait for
         if (eos) begin
            push_codepoint(REPL_CP, 1'b1);
         end else begin
            held_lead_shadow = b;
            lead_held        = 1'b1;
         end
      end else begin
         push_codepoint(REPL_CP, eos);
      end
   endfunction

   // ------------------------------------------------------------------------
   // drivers; every task starts and ends just after a falling edge
   // ------------------------------------------------------------------------

   task automatic send_item(input logic cmd, input logic [7:0] b, input logic eos,
                            input logic [15:0] code, input logic [15:0] cpv);
      int gap;
      gap = (req_gap_max > 0) ? $urandom_range(0, req_gap_max) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_cmd             <= cmd;
      req_data_byte       <= b;
      req_end_of_string   <= eos;
      req_entry_code      <= code;
      req_entry_codepoint <= cpv;
      req_valid           <= 1'b1;
      do @(posedge clock); while (req_ready !== 1'b1);
      transcode_item(cmd, b, eos, code, cpv);
      @(negedge clock);
   endtask

   // fields the block ignores for a given command still carry random values
   task automatic send_decode(input logic [7:0] b, input logic eos);
      send_item(CMD_DECODE, b, eos, 16'($urandom), 16'($urandom));
   endtask

   task automatic send_load(input logic [15:0] code, input logic [15:0] cpv);
      send_item(CMD_LOAD, 8'($urandom), 1'($urandom), code, cpv);
      if (lead_row_of(code[15:8]) >= 0) begin
         loaded_codes = {loaded_codes, code};
      end
   endtask

   // sender holds back until every predicted byte is in, then lets the
   // pipeline settle, since loads and held leads leave nothing to wait for
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (utf8_expected.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic csr_write(input logic m);
      wait_drained();
      csr_charset_mode <= m;
      csr_valid        <= 1'b1;
      do @(posedge clock); while (csr_ready !== 1'b1);
      mode_shadow = m;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // receiver: random stall before each byte, plus the requested long hold
   // ------------------------------------------------------------------------
   initial begin : rsp_sink
      int gap;
      rsp_ready = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         gap = (rsp_gap_max > 0) ? $urandom_range(0, rsp_gap_max) : 0;
         if (rsp_hold_cycles > 0) begin
            gap             = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         @(negedge clock);
      end
   end

   // ------------------------------------------------------------------------
   // checker: each rsp transaction against the oldest prediction
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : rsp_check
      utf8_beat_type want;
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (utf8_expected.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected byte %02h last %0b end %0b", rsp_utf8_byte,
                        rsp_run_last, rsp_string_end);
            end
         end else begin
            want = utf8_expected.pop_front();
            if (rsp_utf8_byte !== want.utf8_byte || rsp_run_last !== want.run_last ||
                rsp_string_end !== want.string_end) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch: expected %02h last %0b end %0b, got %02h last %0b end %0b",
                           want.utf8_byte, want.run_last, want.string_end,
                           rsp_utf8_byte, rsp_run_last, rsp_string_end);
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // random item builders
   // ------------------------------------------------------------------------

   function automatic logic [7:0] random_lead();
      if ($urandom_range(0, 1) == 0) begin
         return 8'($urandom_range(LEAD1_LO, LEAD1_HI));
      end
      return 8'($urandom_range(LEAD2_LO, LEAD2_HI));
   endfunction

   // codepoint spread over the one, two and three byte encodings
   function automatic logic [15:0] random_codepoint();
      case ($urandom_range(0, 2))
         0: begin
            return 16'($urandom_range(0, 16'h007F));
         end
         1: begin
            return 16'($urandom_range(16'h0080, 16'h07FF));
         end
         default: begin
            return 16'($urandom_range(16'h0800, 16'hFFFF));
         end
      endcase
   endfunction

   task automatic random_load();
      logic [15:0] code;
      // mostly good leads, some fully random codes, dropped when their lead is bad
      if ($urandom_range(0, 3) != 0) begin
         code = {random_lead(), 8'($urandom)};
      end else begin
         code = 16'($urandom);
      end
      send_load(code, random_codepoint());
   endtask

   // shift-jis traffic: mostly well-formed text, some loads and some noise
   task automatic random_sjis_item();
      int          pick;
      logic [15:0] code;
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         random_load();
      end else if (pick < 32) begin
         send_decode(8'($urandom_range(0, 16'h7F)), $urandom_range(0, 3) == 0);
      end else if (pick < 47) begin
         send_decode(8'($urandom_range(KANA_LO, KANA_HI)), $urandom_range(0, 3) == 0);
      end else if (pick < 82) begin
         // double-byte pair, usually one that is in the table
         if (loaded_codes.size() > 0 && $urandom_range(0, 2) != 0) begin
            code = loaded_codes[$urandom_range(0, loaded_codes.size() - 1)];
         end else begin
            code = {random_lead(), 8'($urandom)};
         end
         send_decode(code[15:8], $urandom_range(0, 19) == 0);
         send_decode(code[7:0], $urandom_range(0, 3) == 0);
      end else begin
         send_decode(8'($urandom), 1'($urandom));
      end
   endtask

   task automatic random_latin1_item();
      if ($urandom_range(0, 9) == 0) begin
         random_load();
      end else begin
         send_decode(8'($urandom), $urandom_range(0, 3) == 0);
      end
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   task automatic test_latin1_bytes();
      csr_write(MODE_LATIN1);
      send_decode(8'h00, 1'b0);
      send_decode(8'h7F, 1'b1);
      send_decode(8'h80, 1'b0);
      send_decode(8'hFF, 1'b1);
   endtask

   task automatic test_table_load();
      csr_write(MODE_SJIS);
      send_load(16'h8140, 16'h3000);
      send_load(16'hFCFF, 16'h07FF);
      send_load(16'h9F00, 16'h007F);
      send_load(16'hE080, 16'hFFFF);
      send_load(16'h8800, 16'h0080);
      // lead outside both ranges: dropped
      send_load(16'hA040, 16'h1234);
   endtask

   task automatic test_single_bytes();
      send_decode(8'h00, 1'b0);
      send_decode(8'h7F, 1'b1);
      // halfwidth katakana edges
      send_decode(KANA_LO, 1'b0);
      send_decode(KANA_HI, 1'b1);
      // bytes that are neither ascii, kana nor lead
      send_decode(8'h80, 1'b0);
      send_decode(8'hA0, 1'b0);
      send_decode(8'hFD, 1'b0);
      send_decode(8'hFF, 1'b1);
   endtask

   task automatic test_double_bytes();
      send_decode(8'h81, 1'b0);
      send_decode(8'h40, 1'b0);
      send_decode(8'hFC, 1'b0);
      send_decode(8'hFF, 1'b1);
      send_decode(8'h9F, 1'b0);
      send_decode(8'h00, 1'b0);
      send_decode(8'hE0, 1'b0);
      send_decode(8'h80, 1'b1);
      // pair never loaded
      send_decode(8'h82, 1'b0);
      send_decode(8'h41, 1'b0);
      // lead closing a string is replaced, not held
      send_decode(8'h81, 1'b1);
      // load slipped in under a held lead; trail that is itself a lead value
      send_decode(8'hE0, 1'b0);
      send_load(16'h8141, 16'h0800);
      send_decode(8'h81, 1'b0);
      send_decode(8'h81, 1'b0);
      send_decode(8'h41, 1'b1);
   endtask

   task automatic test_held_lead_mode();
      // mode writes leave a held lead alone
      send_decode(8'h88, 1'b0);
      csr_write(MODE_LATIN1);
      csr_write(MODE_SJIS);
      send_decode(8'h00, 1'b1);
      // a latin-1 decode drops it
      send_decode(8'h82, 1'b0);
      csr_write(MODE_LATIN1);
      send_decode(8'hE9, 1'b0);
      csr_write(MODE_SJIS);
      send_decode(8'h40, 1'b1);
   endtask

   task automatic run_phase(input logic m, input int n, input int req_gap,
                            input int rsp_gap);
      csr_write(m);
      req_gap_max = req_gap;
      rsp_gap_max = rsp_gap;
      repeat (n) begin
         if (m == MODE_SJIS) begin
            random_sjis_item();
         end else begin
            random_latin1_item();
         end
      end
   endtask

   task automatic test_random_traffic();
      run_phase(MODE_SJIS,   35, 6, 6);
      run_phase(MODE_SJIS,   30, 0, 0);
      run_phase(MODE_LATIN1, 25, 6, 0);
      run_phase(MODE_SJIS,   35, 0, 6);
      run_phase(MODE_LATIN1, 20, 6, 6);
      run_phase(MODE_SJIS,   40, 6, 6);
   endtask

   // receiver stops for a long while with the sender flat out, so the
   // block fills and drops req_ready; then the sender waits for the drain
   task automatic test_backpressure();
      csr_write(MODE_SJIS);
      req_gap_max     = 0;
      rsp_gap_max     = 0;
      rsp_hold_cycles = 150;
      repeat (25) begin
         send_decode(8'($urandom_range(KANA_LO, KANA_HI)), 1'($urandom));
      end
      wait_drained();
      req_gap_max = 6;
      rsp_gap_max = 6;
      repeat (15) random_sjis_item();
   endtask

   // ------------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------------
   initial begin
      reset               = 1'b1;
      csr_valid           = 1'b0;
      csr_charset_mode    = MODE_LATIN1;
      req_valid           = 1'b0;
      req_cmd             = CMD_DECODE;
      req_data_byte       = 8'h00;
      req_end_of_string   = 1'b0;
      req_entry_code      = 16'h0000;
      req_entry_codepoint = 16'h0000;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // req_ready stays low through the table clear, the first send just waits
      test_latin1_bytes();
      test_table_load();
      test_single_bytes();
      test_double_bytes();
      test_held_lead_mode();
      test_random_traffic();
      test_backpressure();

      wait_drained();
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
